// File: rtl/icmp_echo_reply_builder_top_macros.svh
// assertion macros for the icmp echo reply builder
`ifndef ICMP_ECHO_REPLY_BUILDER_TOP_MACROS_SVH
`define ICMP_ECHO_REPLY_BUILDER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ICMP_ERB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("icmp_erb assertion failed");
// next-cycle implication
`define ICMP_ERB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("icmp_erb assertion failed");
`else
`define ICMP_ERB_ASSERT_IMP(lbl, ante, cons)
`define ICMP_ERB_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// File: rtl/icmp_erb_pkg.sv
package icmp_erb_pkg;

  // frame geometry
  localparam int MAX_FRAME   = 2048;
  localparam int ETH_HDR_LEN = 14;
  localparam int ADDR_W      = $clog2(MAX_FRAME);
  localparam int CNT_W       = $clog2(MAX_FRAME + 32);
  localparam int SUM_W       = 16 + $clog2(MAX_FRAME);

  // byte positions in the received frame
  localparam int VER_POS   = ETH_HDR_LEN;
  localparam int PROTO_POS = ETH_HDR_LEN + 9;
  localparam int SRC_POS   = ETH_HDR_LEN + 12;
  localparam int DST_POS   = ETH_HDR_LEN + 16;

  // reply layout
  localparam int REPLY_HDR_LEN = 28;
  localparam int ICMP_HDR_LEN  = 8;

  // protocol codes
  localparam logic [3:0] IP_VERSION     = 4'd4;
  localparam logic [7:0] IP_VER_IHL     = 8'h45;
  localparam logic [7:0] PROTO_ICMP     = 8'd1;
  localparam logic [7:0] ICMP_ECHO_REQ  = 8'd8;
  localparam logic [7:0] ICMP_ECHO_REP  = 8'd0;
  localparam logic [7:0] TTL_RESET      = 8'd64;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_FRAME,
    OP_LOAD,
    OP_FETCH
  } op_kind_t;

  typedef enum logic [2:0] {
    FR_RUN,
    FR_SUM,
    FR_ADD,
    FR_FOLD_A,
    FR_FOLD_B,
    FR_PUSH
  } front_state_t;

  typedef struct packed {
    logic [CNT_W-1:0] len;
    logic [CNT_W-1:0] pay_base;
    logic [7:0]       ttl;
    logic [31:0]      src;
    logic [31:0]      dst;
    logic [31:0]      idseq;
    logic [15:0]      ip_ck;
    logic [15:0]      icmp_ck;
  } reply_desc_t;

  typedef struct packed {
    op_kind_t          kind;
    logic              store;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
    reply_desc_t       desc;
  } queue_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// File: rtl/icmp_echo_reply_builder_top.sv
// ICMP echo responder. Frame bytes (tuser 0) are taken one per cycle and stored.
// At the frame's tlast byte the port stalls while the frame is judged. When the
// frame is an IPv4 echo request it stays stalled while the reply header
// checksums are folded, and longer if the queue is full by then. Each fetch
// transaction (tuser 1) yields exactly one result: the next reply byte with
// tuser 1 (tlast on the final one), or a zero byte with tuser 0 when no reply
// is pending. Fetches run at one per cycle when the result side takes them. A
// result is registered: the fetch passes through the two-entry queue between
// the parser and the reply engine, then sets the output register. Payload bytes
// come from the registered read of the frame store, which runs in step with the
// output register. While results are held off the queue fills and the input
// stalls. A frame byte discards any pending reply. reply_ttl is written with
// cfg_wr_en and resets to 64.
`include "icmp_echo_reply_builder_top_macros.svh"

module icmp_echo_reply_builder_top (
  input  logic       clk,
  input  logic       rst_n,
  // input stream
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // in_last
  input  logic       in_tuser,   // [0] req_type
  // result stream
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,  // out_last
  output logic       out_tuser,  // [0] out_valid
  // reply_ttl register
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  logic                        q_push;
  logic                        q_pop;
  icmp_erb_pkg::queue_entry_t  q_wdata;
  icmp_erb_pkg::queue_entry_t  q_rdata;
  icmp_erb_pkg::queue_status_t q_status;

  // parser and frame judge
  icmp_erb_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .in_tuser    (in_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_push      (q_push),
    .q_wdata     (q_wdata),
    .q_status    (q_status)
  );

  // op queue
  icmp_erb_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .pop    (q_pop),
    .rdata  (q_rdata),
    .status (q_status)
  );

  // frame store and reply engine
  icmp_erb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_rdata    (q_rdata),
    .q_status   (q_status),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // checks
  `ICMP_ERB_ASSERT_IMP(a_queue_no_overflow, q_push, !q_status.full)
  `ICMP_ERB_ASSERT_IMP(a_queue_no_underflow, q_pop, !q_status.empty)
  `ICMP_ERB_ASSERT_IMP(a_idle_result_zero, out_tvalid && !out_tuser, !out_tlast && out_tdata == 8'h00)
  `ICMP_ERB_ASSERT_NXT(a_frame_end_stalls, in_tvalid && in_tready && !in_tuser && in_tlast, !in_tready)

endmodule

// File: rtl/icmp_erb_ram.sv
module icmp_erb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/icmp_erb_queue.sv
module icmp_erb_queue (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  icmp_erb_pkg::queue_entry_t wdata,
  input  logic                       pop,
  output icmp_erb_pkg::queue_entry_t rdata,
  output icmp_erb_pkg::queue_status_t status
);

  icmp_erb_pkg::queue_entry_t entries_r [icmp_erb_pkg::QUEUE_DEPTH];
  logic [icmp_erb_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [icmp_erb_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [icmp_erb_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;

  localparam logic [icmp_erb_pkg::QPTR_W-1:0] LAST_SLOT =
    icmp_erb_pkg::QPTR_W'(icmp_erb_pkg::QUEUE_DEPTH - 1);

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + 1'b1;
    end
    priority if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata        = entries_r[rd_ptr_r];
  assign status.full  = (cnt_r == icmp_erb_pkg::QCNT_W'(icmp_erb_pkg::QUEUE_DEPTH));
  assign status.empty = (cnt_r == '0);

endmodule

// File: rtl/icmp_erb_front.sv
module icmp_erb_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,
  input  logic                        in_tlast,
  input  logic                        in_tuser,
  input  logic                        cfg_wr_en,
  input  logic [7:0]                  cfg_wr_data,
  output logic                        q_push,
  output icmp_erb_pkg::queue_entry_t  q_wdata,
  input  icmp_erb_pkg::queue_status_t q_status
);

  localparam int CW = icmp_erb_pkg::CNT_W;
  localparam int SW = icmp_erb_pkg::SUM_W;

  icmp_erb_pkg::front_state_t state_r, state_nxt;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] icmp_pos_r, icmp_pos_nxt;
  logic [CW-1:0] len_r, len_nxt;
  logic          ovf_r, ovf_nxt;
  logic          ver_ok_r, ver_ok_nxt;
  logic          proto_ok_r, proto_ok_nxt;
  logic          type_ok_r, type_ok_nxt;
  logic [31:0]   src_r, src_nxt;
  logic [31:0]   dst_r, dst_nxt;
  logic [31:0]   idseq_r, idseq_nxt;
  logic [SW-1:0] sum_r, sum_nxt;
  logic [SW-1:0] icmp_s_r, icmp_s_nxt;
  logic [SW-1:0] ip_s_r, ip_s_nxt;
  logic [7:0]    ttl_r;
  logic [7:0]    ttl_s_r, ttl_s_nxt;

  logic          acc_frame, acc_fetch, in_ip;
  logic          frame_ok;
  logic [CW-1:0] src_off, dst_off, id_off;

  // write one byte of a big-endian word, position 0 is the top byte
  function automatic logic [31:0] put_byte(input logic [31:0] w, input logic [1:0] pos,
                                           input logic [7:0] b);
    logic [31:0] r;
    r = w;
    unique case (pos)
      2'd0: r[31:24] = b;
      2'd1: r[23:16] = b;
      2'd2: r[15:8]  = b;
      2'd3: r[7:0]   = b;
      default: r = w;
    endcase
    return r;
  endfunction

  // one end-around carry fold of a one's complement sum
  function automatic logic [SW-1:0] fold16(input logic [SW-1:0] s);
    return SW'({1'b0, s[15:0]} + 17'(s[SW-1:16]));
  endfunction

  assign acc_frame = in_tvalid && in_tready && !in_tuser;
  assign acc_fetch = in_tvalid && in_tready && in_tuser;
  assign in_ip     = cnt_r > CW'(icmp_erb_pkg::VER_POS);
  assign src_off   = cnt_r - CW'(icmp_erb_pkg::SRC_POS);
  assign dst_off   = cnt_r - CW'(icmp_erb_pkg::DST_POS);
  assign id_off    = cnt_r - icmp_pos_r - CW'(4);

  // frame verdict from the captured header fields
  assign frame_ok = !ovf_r && ver_ok_r && proto_ok_r && type_ok_r &&
                    (n_r >= icmp_pos_r + CW'(icmp_erb_pkg::ICMP_HDR_LEN));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      icmp_erb_pkg::FR_RUN: begin
        if (acc_frame && in_tlast) begin
          state_nxt = icmp_erb_pkg::FR_SUM;
        end
      end
      icmp_erb_pkg::FR_SUM: begin
        state_nxt = frame_ok ? icmp_erb_pkg::FR_ADD : icmp_erb_pkg::FR_RUN;
      end
      icmp_erb_pkg::FR_ADD:    state_nxt = icmp_erb_pkg::FR_FOLD_A;
      icmp_erb_pkg::FR_FOLD_A: state_nxt = icmp_erb_pkg::FR_FOLD_B;
      icmp_erb_pkg::FR_FOLD_B: state_nxt = icmp_erb_pkg::FR_PUSH;
      icmp_erb_pkg::FR_PUSH: begin
        if (!q_status.full) begin
          state_nxt = icmp_erb_pkg::FR_RUN;
        end
      end
      default: state_nxt = icmp_erb_pkg::FR_RUN;
    endcase
  end

  // handshake and queue writes
  always_comb begin
    in_tready = (state_r == icmp_erb_pkg::FR_RUN) && !q_status.full;
    q_push    = 1'b0;
    q_wdata   = '0;
    unique case (state_r)
      icmp_erb_pkg::FR_RUN: begin
        if (acc_frame) begin
          q_push        = 1'b1;
          q_wdata.kind  = icmp_erb_pkg::OP_FRAME;
          q_wdata.store = cnt_r < CW'(icmp_erb_pkg::MAX_FRAME);
          q_wdata.addr  = cnt_r[icmp_erb_pkg::ADDR_W-1:0];
          q_wdata.data  = in_tdata;
        end else if (acc_fetch) begin
          q_push       = 1'b1;
          q_wdata.kind = icmp_erb_pkg::OP_FETCH;
        end
      end
      icmp_erb_pkg::FR_PUSH: begin
        q_push                = !q_status.full;
        q_wdata.kind          = icmp_erb_pkg::OP_LOAD;
        q_wdata.desc.len      = len_r;
        q_wdata.desc.pay_base = icmp_pos_r + CW'(icmp_erb_pkg::ICMP_HDR_LEN);
        q_wdata.desc.ttl      = ttl_s_r;
        q_wdata.desc.src      = src_r;
        q_wdata.desc.dst      = dst_r;
        q_wdata.desc.idseq    = idseq_r;
        q_wdata.desc.ip_ck    = ~ip_s_r[15:0];
        q_wdata.desc.icmp_ck  = ~icmp_s_r[15:0];
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

  // per-byte header capture and payload sum
  always_comb begin
    cnt_nxt      = cnt_r;
    n_nxt        = n_r;
    icmp_pos_nxt = icmp_pos_r;
    ovf_nxt      = ovf_r;
    ver_ok_nxt   = ver_ok_r;
    proto_ok_nxt = proto_ok_r;
    type_ok_nxt  = type_ok_r;
    src_nxt      = src_r;
    dst_nxt      = dst_r;
    idseq_nxt    = idseq_r;
    sum_nxt      = sum_r;
    if (acc_frame) begin
      // a new frame starts clean
      if (cnt_r == '0) begin
        icmp_pos_nxt = '0;
        ovf_nxt      = 1'b0;
        ver_ok_nxt   = 1'b0;
        proto_ok_nxt = 1'b0;
        type_ok_nxt  = 1'b0;
        src_nxt      = '0;
        dst_nxt      = '0;
        idseq_nxt    = '0;
        sum_nxt      = '0;
      end
      if (cnt_r >= CW'(icmp_erb_pkg::MAX_FRAME)) begin
        ovf_nxt = 1'b1;
      end
      if (cnt_r == CW'(icmp_erb_pkg::VER_POS)) begin
        ver_ok_nxt   = in_tdata[7:4] == icmp_erb_pkg::IP_VERSION;
        icmp_pos_nxt = CW'(icmp_erb_pkg::VER_POS) + CW'({in_tdata[3:0], 2'b00});
      end
      if (cnt_r == CW'(icmp_erb_pkg::PROTO_POS)) begin
        proto_ok_nxt = in_tdata == icmp_erb_pkg::PROTO_ICMP;
      end
      if (cnt_r >= CW'(icmp_erb_pkg::SRC_POS) && src_off < CW'(4)) begin
        src_nxt = put_byte(src_r, src_off[1:0], in_tdata);
      end
      if (cnt_r >= CW'(icmp_erb_pkg::DST_POS) && dst_off < CW'(4)) begin
        dst_nxt = put_byte(dst_r, dst_off[1:0], in_tdata);
      end
      // icmp fields relative to the header length
      if (in_ip && cnt_r == icmp_pos_r) begin
        type_ok_nxt = in_tdata == icmp_erb_pkg::ICMP_ECHO_REQ;
      end
      if (in_ip && cnt_r >= icmp_pos_r + CW'(4) && id_off < CW'(4)) begin
        idseq_nxt = put_byte(idseq_r, id_off[1:0], in_tdata);
      end
      if (in_ip && cnt_r >= icmp_pos_r + CW'(icmp_erb_pkg::ICMP_HDR_LEN) &&
          cnt_r < CW'(icmp_erb_pkg::MAX_FRAME)) begin
        if (cnt_r[0] ^ icmp_pos_r[0]) begin
          sum_nxt = sum_r + SW'(in_tdata);
        end else begin
          sum_nxt = sum_r + SW'({in_tdata, 8'h00});
        end
      end
      // byte count saturates just past the store
      if (in_tlast) begin
        cnt_nxt = '0;
        n_nxt   = cnt_r + 1'b1;
      end else if (cnt_r <= CW'(icmp_erb_pkg::MAX_FRAME)) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  // checksum sequence after a qualifying frame
  always_comb begin
    icmp_s_nxt = icmp_s_r;
    ip_s_nxt   = ip_s_r;
    ttl_s_nxt  = ttl_s_r;
    len_nxt    = len_r;
    unique case (state_r)
      icmp_erb_pkg::FR_SUM: begin
        icmp_s_nxt = sum_r + SW'(idseq_r[31:16]) + SW'(idseq_r[15:0]);
        ip_s_nxt   = SW'(src_r[31:16]) + SW'(src_r[15:0]) +
                     SW'(dst_r[31:16]) + SW'(dst_r[15:0]);
        ttl_s_nxt  = ttl_r;
        len_nxt    = n_r - icmp_pos_r +
                     CW'(icmp_erb_pkg::REPLY_HDR_LEN - icmp_erb_pkg::ICMP_HDR_LEN);
      end
      icmp_erb_pkg::FR_ADD: begin
        ip_s_nxt   = ip_s_r + SW'({icmp_erb_pkg::IP_VER_IHL, 8'h00}) +
                     SW'(icmp_erb_pkg::PROTO_ICMP) + SW'(len_r) + SW'({ttl_s_r, 8'h00});
        icmp_s_nxt = fold16(icmp_s_r);
      end
      icmp_erb_pkg::FR_FOLD_A, icmp_erb_pkg::FR_FOLD_B: begin
        ip_s_nxt   = fold16(ip_s_r);
        icmp_s_nxt = fold16(icmp_s_r);
      end
      default: begin
        len_nxt = len_r;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= icmp_erb_pkg::FR_RUN;
      cnt_r      <= '0;
      ovf_r      <= 1'b0;
      ver_ok_r   <= 1'b0;
      proto_ok_r <= 1'b0;
      type_ok_r  <= 1'b0;
      ttl_r      <= icmp_erb_pkg::TTL_RESET;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      ovf_r      <= ovf_nxt;
      ver_ok_r   <= ver_ok_nxt;
      proto_ok_r <= proto_ok_nxt;
      type_ok_r  <= type_ok_nxt;
      if (cfg_wr_en) begin
        ttl_r <= cfg_wr_data;
      end
    end
  end

  // capture and checksum registers
  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    icmp_pos_r <= icmp_pos_nxt;
    src_r      <= src_nxt;
    dst_r      <= dst_nxt;
    idseq_r    <= idseq_nxt;
    sum_r      <= sum_nxt;
    icmp_s_r   <= icmp_s_nxt;
    ip_s_r     <= ip_s_nxt;
    ttl_s_r    <= ttl_s_nxt;
    len_r      <= len_nxt;
  end

endmodule

// File: rtl/icmp_erb_back.sv
module icmp_erb_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  icmp_erb_pkg::queue_entry_t  q_rdata,
  input  icmp_erb_pkg::queue_status_t q_status,
  output logic                        q_pop,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [7:0]                  out_tdata,
  output logic                        out_tlast,
  output logic                        out_tuser
);

  localparam int CW = icmp_erb_pkg::CNT_W;
  localparam int AW = icmp_erb_pkg::ADDR_W;

  icmp_erb_pkg::reply_desc_t desc_r, desc_nxt;
  logic          pending_r, pending_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic          out_last_r, out_last_nxt;
  logic          out_user_r, out_user_nxt;
  logic          out_mem_r, out_mem_nxt;
  logic [7:0]    out_hdr_r, out_hdr_nxt;

  logic          ram_wr_en, ram_rd_en;
  logic [AW-1:0] ram_rd_addr;
  logic [7:0]    ram_rd_data;
  logic [7:0]    hdr_byte;
  logic [15:0]   len16;
  logic          at_end, in_hdr;

  assign len16  = 16'(desc_r.len);
  assign at_end = ({1'b0, ptr_r} + 1'b1) >= {1'b0, desc_r.len};
  assign in_hdr = ptr_r < CW'(icmp_erb_pkg::REPLY_HDR_LEN);

  // payload bytes are read back from the frame store
  assign ram_rd_addr = AW'(ptr_r + desc_r.pay_base - CW'(icmp_erb_pkg::REPLY_HDR_LEN));

  // fetches wait for a free output slot, other ops never stall
  assign q_pop = !q_status.empty &&
                 (q_rdata.kind != icmp_erb_pkg::OP_FETCH || !out_valid_r || out_tready);

  // reply ip and icmp header bytes
  always_comb begin
    unique case (ptr_r[4:0])
      5'd0:    hdr_byte = icmp_erb_pkg::IP_VER_IHL;
      5'd2:    hdr_byte = len16[15:8];
      5'd3:    hdr_byte = len16[7:0];
      5'd8:    hdr_byte = desc_r.ttl;
      5'd9:    hdr_byte = icmp_erb_pkg::PROTO_ICMP;
      5'd10:   hdr_byte = desc_r.ip_ck[15:8];
      5'd11:   hdr_byte = desc_r.ip_ck[7:0];
      5'd12:   hdr_byte = desc_r.dst[31:24];
      5'd13:   hdr_byte = desc_r.dst[23:16];
      5'd14:   hdr_byte = desc_r.dst[15:8];
      5'd15:   hdr_byte = desc_r.dst[7:0];
      5'd16:   hdr_byte = desc_r.src[31:24];
      5'd17:   hdr_byte = desc_r.src[23:16];
      5'd18:   hdr_byte = desc_r.src[15:8];
      5'd19:   hdr_byte = desc_r.src[7:0];
      5'd20:   hdr_byte = icmp_erb_pkg::ICMP_ECHO_REP;
      5'd22:   hdr_byte = desc_r.icmp_ck[15:8];
      5'd23:   hdr_byte = desc_r.icmp_ck[7:0];
      5'd24:   hdr_byte = desc_r.idseq[31:24];
      5'd25:   hdr_byte = desc_r.idseq[23:16];
      5'd26:   hdr_byte = desc_r.idseq[15:8];
      5'd27:   hdr_byte = desc_r.idseq[7:0];
      default: hdr_byte = 8'h00;
    endcase
  end

  // carry out the op at the head of the queue
  always_comb begin
    desc_nxt      = desc_r;
    pending_nxt   = pending_r;
    ptr_nxt       = ptr_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_last_nxt  = out_last_r;
    out_user_nxt  = out_user_r;
    out_mem_nxt   = out_mem_r;
    out_hdr_nxt   = out_hdr_r;
    ram_wr_en     = 1'b0;
    ram_rd_en     = 1'b0;
    if (q_pop) begin
      unique case (q_rdata.kind)
        icmp_erb_pkg::OP_FRAME: begin
          pending_nxt = 1'b0;
          ram_wr_en   = q_rdata.store;
        end
        icmp_erb_pkg::OP_LOAD: begin
          desc_nxt    = q_rdata.desc;
          pending_nxt = 1'b1;
          ptr_nxt     = '0;
        end
        icmp_erb_pkg::OP_FETCH: begin
          out_valid_nxt = 1'b1;
          if (!pending_r) begin
            out_user_nxt = 1'b0;
            out_last_nxt = 1'b0;
            out_mem_nxt  = 1'b0;
            out_hdr_nxt  = 8'h00;
          end else begin
            out_user_nxt = 1'b1;
            out_last_nxt = at_end;
            out_mem_nxt  = !in_hdr;
            out_hdr_nxt  = in_hdr ? hdr_byte : 8'h00;
            ram_rd_en    = !in_hdr;
            if (at_end) begin
              pending_nxt = 1'b0;
              ptr_nxt     = '0;
            end else begin
              ptr_nxt = ptr_r + 1'b1;
            end
          end
        end
        default: begin
          pending_nxt = pending_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r   <= 1'b0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pending_r   <= pending_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    desc_r     <= desc_nxt;
    out_last_r <= out_last_nxt;
    out_user_r <= out_user_nxt;
    out_mem_r  <= out_mem_nxt;
    out_hdr_r  <= out_hdr_nxt;
  end

  // frame store
  icmp_erb_ram #(
    .WIDTH (8),
    .DEPTH (icmp_erb_pkg::MAX_FRAME)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (q_rdata.addr),
    .wr_data (q_rdata.data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_mem_r ? ram_rd_data : out_hdr_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

endmodule

// File: dv/tb_icmp_echo_reply_builder_top.sv
`timescale 1ns / 100ps

module tb_icmp_echo_reply_builder_top;

  localparam int         MAX_FRAME     = icmp_erb_pkg::MAX_FRAME;
  localparam int         ETH_HDR_LEN   = icmp_erb_pkg::ETH_HDR_LEN;
  localparam int         VER_POS       = icmp_erb_pkg::VER_POS;
  localparam int         PROTO_POS     = icmp_erb_pkg::PROTO_POS;
  localparam int         SRC_POS       = icmp_erb_pkg::SRC_POS;
  localparam int         DST_POS       = icmp_erb_pkg::DST_POS;
  localparam int         REPLY_HDR_LEN = icmp_erb_pkg::REPLY_HDR_LEN;
  localparam int         ICMP_HDR_LEN  = icmp_erb_pkg::ICMP_HDR_LEN;
  localparam logic [3:0] IP_VERSION    = icmp_erb_pkg::IP_VERSION;
  localparam logic [7:0] IP_VER_IHL    = icmp_erb_pkg::IP_VER_IHL;
  localparam logic [7:0] PROTO_ICMP    = icmp_erb_pkg::PROTO_ICMP;
  localparam logic [7:0] ICMP_ECHO_REQ = icmp_erb_pkg::ICMP_ECHO_REQ;
  localparam logic [7:0] ICMP_ECHO_REP = icmp_erb_pkg::ICMP_ECHO_REP;
  localparam logic [7:0] TTL_RESET     = icmp_erb_pkg::TTL_RESET;

  localparam logic REQ_FRAME   = 1'b0;
  localparam logic REQ_FETCH   = 1'b1;
  localparam int   IP_MIN_HDR  = 20;
  localparam int   IDLE_PCT    = 29;
  localparam int   HOLD_CYCLES = 400;
  localparam int   DRAIN_PAUSE = 16;
  localparam int   STALL_LIMIT = 4000;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       valid;
  } reply_byte_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tlast = 1'b0;
  logic       in_tuser = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic       out_tuser;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'h00;

  icmp_echo_reply_builder_top DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #1 clk = ~clk;

  // traffic control and bookkeeping
  bit          idle_on = 1'b1;
  int          hold_req = 0;
  int          hold_left = 0;
  int          items_sent = 0;
  int          results_seen = 0;
  int          replies_done = 0;
  int          errors = 0;
  int          stall_cycles = 0;
  logic [7:0]  frame_buf [];

  // responder model state
  logic [7:0]  frame_mem [MAX_FRAME];
  int unsigned frame_cnt = 0;
  bit          frame_ovf = 1'b0;
  logic [7:0]  reply_hdr [REPLY_HDR_LEN];
  bit          reply_busy = 1'b0;
  int unsigned reply_len = 0;
  int unsigned reply_ptr = 0;
  int unsigned pay_base = 0;
  logic [7:0]  ttl_model = TTL_RESET;
  reply_byte_t reply_bytes_due [$];

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    $display("mismatch: %s got %02h want %02h at result %0d", what, got, want,
             results_seen);
    errors++;
  endtask

  // bytes past the captured frame read as zero
  function automatic logic [7:0] frame_byte(int unsigned idx, int unsigned n);
    return (idx < n && idx < MAX_FRAME) ? frame_mem[idx] : 8'h00;
  endfunction

  function automatic logic [15:0] fold_ones_sum(logic [31:0] acc);
    while (acc[31:16] != 16'h0000)
      acc = {16'h0000, acc[15:0]} + {16'h0000, acc[31:16]};
    return ~acc[15:0];
  endfunction

  // decide on a finished frame and lay out the reply header
  function automatic void judge_frame();
    int unsigned n, hl, len, dlen;
    logic [7:0]  b0;
    logic [31:0] acc, src, dst;
    logic [15:0] ck;
    n = frame_cnt;
    frame_cnt = 0;
    if (frame_ovf) begin
      frame_ovf = 1'b0;
      return;
    end
    if (n < ETH_HDR_LEN) return;
    len = n - ETH_HDR_LEN;
    b0 = frame_byte(VER_POS, n);
    if (b0[7:4] != IP_VERSION) return;
    if (frame_byte(PROTO_POS, n) != PROTO_ICMP) return;
    hl = 4 * int'(b0[3:0]);
    if (len < hl + ICMP_HDR_LEN) return;
    if (frame_byte(ETH_HDR_LEN + hl, n) != ICMP_ECHO_REQ) return;
    dlen = len - hl - ICMP_HDR_LEN;
    pay_base = ETH_HDR_LEN + hl + ICMP_HDR_LEN;
    acc = 32'h0;
    for (int unsigned i = 0; i < dlen; i += 2)
      acc += {16'h0000, frame_byte(pay_base + i, n),
              (i + 1 < dlen) ? frame_byte(pay_base + i + 1, n) : 8'h00};
    src = 32'h0;
    dst = 32'h0;
    for (int i = 0; i < 4; i++) begin
      src = {src[23:0], frame_byte(SRC_POS + i, n)};
      dst = {dst[23:0], frame_byte(DST_POS + i, n)};
    end
    reply_len = REPLY_HDR_LEN + dlen;
    foreach (reply_hdr[i]) reply_hdr[i] = 8'h00;
    reply_hdr[0] = IP_VER_IHL;
    reply_hdr[2] = 8'(reply_len >> 8);
    reply_hdr[3] = 8'(reply_len);
    reply_hdr[8] = ttl_model;
    reply_hdr[9] = PROTO_ICMP;
    for (int i = 0; i < 4; i++) begin
      reply_hdr[12 + i] = dst[31 - 8 * i -: 8];
      reply_hdr[16 + i] = src[31 - 8 * i -: 8];
    end
    acc = 32'h0;
    for (int i = 0; i < IP_MIN_HDR; i += 2)
      acc += {16'h0000, reply_hdr[i], reply_hdr[i + 1]};
    ck = fold_ones_sum(acc);
    reply_hdr[10] = ck[15:8];
    reply_hdr[11] = ck[7:0];
    reply_hdr[20] = ICMP_ECHO_REP;
    // id and sequence copied from the request
    for (int i = 0; i < 4; i++)
      reply_hdr[24 + i] = frame_byte(ETH_HDR_LEN + hl + 4 + i, n);
    acc = 32'h0;
    for (int unsigned i = 0; i < dlen; i += 2)
      acc += {16'h0000, frame_byte(pay_base + i, n),
              (i + 1 < dlen) ? frame_byte(pay_base + i + 1, n) : 8'h00};
    acc += {16'h0000, reply_hdr[24], reply_hdr[25]};
    acc += {16'h0000, reply_hdr[26], reply_hdr[27]};
    ck = fold_ones_sum(acc);
    reply_hdr[22] = ck[15:8];
    reply_hdr[23] = ck[7:0];
    reply_ptr = 0;
    reply_busy = 1'b1;
  endfunction

  function automatic void absorb_frame_byte(logic [7:0] b, logic last);
    reply_busy = 1'b0;
    if (frame_cnt < MAX_FRAME) frame_mem[frame_cnt] = b;
    else frame_ovf = 1'b1;
    if (frame_cnt <= MAX_FRAME) frame_cnt++;
    if (last) judge_frame();
  endfunction

  function automatic reply_byte_t next_reply_byte();
    reply_byte_t r = '0;
    int unsigned idx;
    if (!reply_busy) return r;
    if (reply_ptr < REPLY_HDR_LEN) begin
      r.data = reply_hdr[reply_ptr];
    end else begin
      idx = pay_base + reply_ptr - REPLY_HDR_LEN;
      if (idx < MAX_FRAME) r.data = frame_mem[idx];
    end
    r.valid = 1'b1;
    if (reply_ptr + 1 >= reply_len) begin
      r.last = 1'b1;
      reply_busy = 1'b0;
      reply_ptr = 0;
    end else begin
      reply_ptr++;
    end
    return r;
  endfunction

  // predict on accepted inputs, check accepted results, track stalls
  always @(posedge clk) begin : monitor
    reply_byte_t seen, due;
    if (!rst_n) begin
      frame_cnt = 0;
      frame_ovf = 1'b0;
      reply_busy = 1'b0;
      reply_ptr = 0;
      reply_len = 0;
      ttl_model = TTL_RESET;
      reply_bytes_due.delete();
    end else begin
      if (cfg_wr_en) ttl_model = cfg_wr_data;
      if (in_tvalid && in_tready) begin
        if (in_tuser == REQ_FETCH) reply_bytes_due.push_back(next_reply_byte());
        else absorb_frame_byte(in_tdata, in_tlast);
      end
      if (out_tvalid && out_tready) begin
        seen = '{data: out_tdata, last: out_tlast, valid: out_tuser};
        results_seen++;
        if (reply_bytes_due.size() == 0) begin
          report_mismatch("result with nothing due, out_byte", seen.data, 8'h00);
        end else begin
          due = reply_bytes_due.pop_front();
          if (seen.data !== due.data) report_mismatch("out_byte", seen.data, due.data);
          if (seen.last !== due.last)
            report_mismatch("out_last", 8'(seen.last), 8'(due.last));
          if (seen.valid !== due.valid)
            report_mismatch("out_valid", 8'(seen.valid), 8'(due.valid));
          if (due.valid && due.last) replies_done++;
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles = 0;
      else stall_cycles++;
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
    $display("FAIL");
    $finish;
  end

  // result side: random stalls, plus a counted hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_req - 1;
      hold_req <= 0;
    end else begin
      out_tready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // offer one transaction and wait for it to be taken
  task automatic send_item(logic kind, logic [7:0] d, logic last);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= d;
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_buf[i]) send_item(REQ_FRAME, frame_buf[i], i == frame_buf.size() - 1);
  endtask

  task automatic fetch_bytes(int count);
    repeat (count) send_item(REQ_FETCH, 8'($urandom), 1'($urandom));
  endtask

  // fill frame_buf with an echo request, return the reply length it earns
  function automatic int build_echo(int ihl, int pay_len);
    int n;
    n = ETH_HDR_LEN + 4 * ihl + ICMP_HDR_LEN + pay_len;
    if (n < ETH_HDR_LEN + IP_MIN_HDR) n = ETH_HDR_LEN + IP_MIN_HDR;
    frame_buf = new[n];
    foreach (frame_buf[i]) frame_buf[i] = 8'($urandom);
    frame_buf[ETH_HDR_LEN + 4 * ihl] = ICMP_ECHO_REQ;
    frame_buf[PROTO_POS] = PROTO_ICMP;
    frame_buf[VER_POS] = {IP_VERSION, 4'(ihl)};
    return n - ETH_HDR_LEN - 4 * ihl - ICMP_HDR_LEN + REPLY_HDR_LEN;
  endfunction

  // stop offering and let every due result come back
  task automatic wait_drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (reply_bytes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  task automatic write_ttl(logic [7:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic test_fetch_without_reply();
    send_item(REQ_FETCH, 8'hff, 1'b1);
    send_item(REQ_FETCH, 8'h00, 1'b0);
  endtask

  task automatic test_echo_shapes();
    int rlen;
    // no payload, then one fetch beyond the end
    rlen = build_echo(5, 0);
    send_frame();
    fetch_bytes(rlen + 1);
    // odd payload with all-ones source and all-zero destination
    rlen = build_echo(5, 5);
    for (int i = 0; i < 4; i++) begin
      frame_buf[SRC_POS + i] = 8'hff;
      frame_buf[DST_POS + i] = 8'h00;
      frame_buf[i] = 8'hff;
    end
    send_frame();
    fetch_bytes(rlen);
    // all-ones payload drives checksum carries
    rlen = build_echo(5, 6);
    for (int i = 1; i <= 6; i++) frame_buf[frame_buf.size() - i] = 8'hff;
    send_frame();
    fetch_bytes(rlen);
    // header options and the largest header
    rlen = build_echo(6, 4);
    send_frame();
    fetch_bytes(rlen);
    rlen = build_echo(15, 3);
    send_frame();
    fetch_bytes(rlen);
    // header shorter than 20 bytes, icmp overlaps the ip header
    rlen = build_echo(2, 0);
    send_frame();
    fetch_bytes(rlen);
  endtask

  task automatic test_rejected_frames();
    int rlen;
    // shorter than the ethernet header, then exactly the header
    frame_buf = new[10];
    foreach (frame_buf[i]) frame_buf[i] = 8'($urandom);
    send_frame();
    fetch_bytes(1);
    frame_buf = new[ETH_HDR_LEN];
    foreach (frame_buf[i]) frame_buf[i] = 8'($urandom);
    send_frame();
    fetch_bytes(1);
    // protocol byte lies past the end
    rlen = build_echo(5, 8);
    frame_buf = new[PROTO_POS - 1](frame_buf);
    send_frame();
    fetch_bytes(1);
    // wrong version, wrong protocol, wrong icmp type
    rlen = build_echo(5, 4);
    frame_buf[VER_POS] = 8'h65;
    send_frame();
    fetch_bytes(1);
    rlen = build_echo(5, 4);
    frame_buf[PROTO_POS] = 8'd6;
    send_frame();
    fetch_bytes(1);
    rlen = build_echo(5, 4);
    frame_buf[ETH_HDR_LEN + IP_MIN_HDR] = ICMP_ECHO_REP;
    send_frame();
    fetch_bytes(1);
    // one byte short of a full icmp header
    rlen = build_echo(5, 0);
    frame_buf = new[frame_buf.size() - 1](frame_buf);
    send_frame();
    fetch_bytes(1);
  endtask

  task automatic test_reply_discard();
    int rlen;
    // partly fetched reply replaced by a new request
    rlen = build_echo(5, 10);
    send_frame();
    fetch_bytes(10);
    rlen = build_echo(5, 2);
    send_frame();
    fetch_bytes(rlen + 1);
    // two requests back to back, only the second answers
    rlen = build_echo(5, 3);
    send_frame();
    rlen = build_echo(5, 9);
    send_frame();
    fetch_bytes(rlen);
    // reply killed by a frame that does not qualify
    rlen = build_echo(5, 7);
    send_frame();
    fetch_bytes(3);
    frame_buf = new[5];
    foreach (frame_buf[i]) frame_buf[i] = 8'($urandom);
    send_frame();
    fetch_bytes(2);
  endtask

  task automatic test_ttl_settings();
    logic [7:0] ttl_list [5];
    int rlen;
    ttl_list = '{8'd0, 8'd255, 8'd1, 8'($urandom), TTL_RESET};
    foreach (ttl_list[k]) begin
      wait_drain();
      write_ttl(ttl_list[k]);
      rlen = build_echo(5, $urandom_range(8));
      send_frame();
      fetch_bytes(rlen);
    end
  endtask

  task automatic test_receiver_holdoff();
    int rlen;
    rlen = build_echo(5, 40);
    send_frame();
    hold_req <= HOLD_CYCLES;
    fetch_bytes(rlen);
  endtask

  // mostly well-formed requests, some spoiled, some noise and loose fetches
  task automatic run_random_traffic(int budget);
    int goal, sel, ihl, pay, rlen;
    goal = items_sent + budget;
    while (items_sent < goal) begin
      sel = $urandom_range(99);
      if (sel < 70) begin
        ihl = ($urandom_range(9) == 0) ? $urandom_range(15) : 5;
        pay = ($urandom_range(9) == 0) ? $urandom_range(120) : $urandom_range(24);
        rlen = build_echo(ihl, pay);
        if ($urandom_range(99) < 20) begin
          case ($urandom_range(3))
            0: frame_buf[VER_POS] = 8'($urandom);
            1: frame_buf[PROTO_POS] = 8'($urandom);
            2: frame_buf[ETH_HDR_LEN + 4 * ihl] = 8'($urandom);
            default: frame_buf = new[$urandom_range(1, frame_buf.size())](frame_buf);
          endcase
        end
        send_frame();
        case ($urandom_range(3))
          0: fetch_bytes(rlen);
          1: fetch_bytes(rlen + $urandom_range(1, 3));
          2: fetch_bytes($urandom_range(rlen));
          default: ;
        endcase
      end else if (sel < 85) begin
        frame_buf = new[$urandom_range(1, 60)];
        foreach (frame_buf[i]) frame_buf[i] = 8'($urandom);
        send_frame();
        fetch_bytes($urandom_range(3));
      end else begin
        fetch_bytes($urandom_range(1, 4));
      end
    end
  endtask

  task automatic test_random_with_idles();
    idle_on = 1'b1;
    run_random_traffic(120);
  endtask

  task automatic test_random_back_to_back();
    idle_on = 1'b0;
    run_random_traffic(200);
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_fetch_without_reply();
    test_echo_shapes();
    test_rejected_frames();
    test_reply_discard();
    test_ttl_settings();
    test_receiver_holdoff();
    test_random_with_idles();
    test_random_back_to_back();
    wait_drain();
    $display("covered %0d input transactions, %0d results, %0d complete echo replies",
             items_sent, results_seen, replies_done);
    $display("incl. rejected and truncated frames, IHL 0..15, ttl extremes, output hold-off");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/icmp_erb_pkg.sv
rtl/icmp_erb_ram.sv
rtl/icmp_erb_queue.sv
rtl/icmp_erb_front.sv
rtl/icmp_erb_back.sv
rtl/icmp_echo_reply_builder_top.sv
dv/tb_icmp_echo_reply_builder_top.sv
